### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/wsc_pkg.sv
// ----------------------------------------------------------------------------
// wsc_pkg
// Shared types and constants for the wave-table sound channel.
// ----------------------------------------------------------------------------
`default_nettype none

package wsc_pkg;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FREQ  = 2'd2,
        REQ_LEN   = 2'd3
    } t_req;

    // Bus map
    localparam logic [15:0] REG_LO = 16'hFF1A;
    localparam logic [15:0] REG_HI = 16'hFF1E;
    localparam logic [15:0] RAM_LO = 16'hFF30;
    localparam logic [15:0] RAM_HI = 16'hFF3F;

    // Register offsets (low address nibble)
    localparam logic [3:0] REG_DAC  = 4'hA;
    localparam logic [3:0] REG_LEN  = 4'hB;
    localparam logic [3:0] REG_VOL  = 4'hC;
    localparam logic [3:0] REG_PLO  = 4'hD;
    localparam logic [3:0] REG_PHI  = 4'hE;

    localparam int RAM_DEPTH = 16;
    localparam int RAM_AW    = 4;

    localparam logic [11:0] PERIOD_SPAN = 12'd2048;
    localparam logic [8:0]  LENGTH_FULL = 9'd256;

    // Wave RAM control from the channel logic
    typedef struct packed {
        logic                  we;
        logic [RAM_AW-1:0]     waddr;
        logic [7:0]            wdata;
        logic                  re;
        logic [RAM_AW-1:0]     raddr_bus;
        logic [RAM_AW-1:0]     raddr_smp;
    } t_ram_ctl;

    // Registered read data back to the channel logic
    typedef struct packed {
        logic [7:0] bus;
        logic [7:0] smp;
    } t_ram_rd;

    // Timer reload: (2048 - period) * 2
    function automatic logic [12:0] reload_value(input logic [10:0] period);
        logic [11:0] span;
        span = PERIOD_SPAN - {1'b0, period};
        return {span, 1'b0};
    endfunction

    // Volume code 0 mutes, 1..3 shift right by 0..2
    function automatic logic [3:0] vol_shift(input logic [3:0] nib, input logic [1:0] vol);
        logic [3:0] res;
        case (vol)
            2'd0:    res = 4'd0;
            2'd1:    res = nib;
            2'd2:    res = nib >> 1;
            2'd3:    res = nib >> 2;
            default: res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/wavetable_sound_channel.sv
// ----------------------------------------------------------------------------
// wavetable_sound_channel
// Wave-table sound channel: control registers, wave RAM, period timer,
// sample position and length counter behind one valid/stall item stream.
// ----------------------------------------------------------------------------
// Each input item is a bus read, a bus write, a frequency tick or a length
// tick, and produces exactly one result item (read byte, output level,
// length-running flag). Throughput is one item per clock unless the output side
// stalls. An item sits in the input register while the wave RAM is read (both
// read ports are registered and addressed from the state as it stands after the
// item ahead, with write forwarding), then all state updates and the result are
// computed in one pass into the output register. The output register lets a new
// item be taken while a result waits; stall only rises when both the input and
// output registers are full and the output side is stalling. Wave RAM reads as
// zero until written, tracked with one valid bit per byte, so no clearing pass
// is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wavetable_sound_channel (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_bus_address,
    input  wire logic [7:0]  i_write_data,
    // result item channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_data,
    output logic [3:0]       o_output_level,
    output logic             o_length_running
);

    // ---------------- handshake / pipeline control ----------------
    logic        r_in_valid;
    logic [1:0]  r_req;
    logic [15:0] r_addr;
    logic [7:0]  r_data;

    logic        r_out_valid;
    logic [7:0]  r_out_rd;
    logic [3:0]  r_out_level;
    logic        r_out_run;

    logic out_free;   // output register can take a result this cycle
    logic consume;    // item in input register is executed this cycle
    logic in_acc;     // new item accepted this cycle

    assign out_free   = !r_out_valid || !i_out_stall;
    assign consume    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // ---------------- channel state ----------------
    logic        r_dac_on,     n_dac_on;
    logic [7:0]  r_len_reload, n_len_reload;
    logic [8:0]  r_len_count,  n_len_count;
    logic [1:0]  r_vol,        n_vol;
    logic [10:0] r_period,     n_period;
    logic        r_len_gate,   n_len_gate;
    logic        r_trig_seen,  n_trig_seen;
    logic        r_chan_on,    n_chan_on;
    logic [12:0] r_timer,      n_timer;
    logic [4:0]  r_pos,        n_pos;
    logic [3:0]  r_level,      n_level;

    logic [7:0]  rd_byte;
    logic        in_reg;
    logic        in_ram;
    logic [4:0]  pos_inc;     // position after an expiry
    logic [4:0]  n_pos_inc;   // position the next item would expire to
    logic [3:0]  nib;
    logic [10:0] trig_period;

    wsc_pkg::t_ram_ctl ram_ctl;
    wsc_pkg::t_ram_rd  ram_rd;

    assign in_reg  = (r_addr >= wsc_pkg::REG_LO) && (r_addr <= wsc_pkg::REG_HI);
    assign in_ram  = (r_addr >= wsc_pkg::RAM_LO) && (r_addr <= wsc_pkg::RAM_HI);
    assign pos_inc = r_pos + 5'd1;
    // odd positions take the low nibble
    assign nib     = pos_inc[0] ? ram_rd.smp[3:0] : ram_rd.smp[7:4];
    assign trig_period = {r_data[2:0], r_period[7:0]};

    // ---------------- next state ----------------
    always_comb begin
        n_dac_on     = r_dac_on;
        n_len_reload = r_len_reload;
        n_len_count  = r_len_count;
        n_vol        = r_vol;
        n_period     = r_period;
        n_len_gate   = r_len_gate;
        n_trig_seen  = r_trig_seen;
        n_chan_on    = r_chan_on;
        n_timer      = r_timer;
        n_pos        = r_pos;
        n_level      = r_level;
        rd_byte      = 8'd0;

        if (consume) begin
            case (wsc_pkg::t_req'(r_req))
                wsc_pkg::REQ_READ: begin
                    if (in_reg) begin
                        case (r_addr[3:0])
                            wsc_pkg::REG_DAC: rd_byte = {r_dac_on, 7'd0};
                            wsc_pkg::REG_LEN: rd_byte = r_len_reload;
                            wsc_pkg::REG_VOL: rd_byte = {1'b0, r_vol, 5'd0};
                            wsc_pkg::REG_PLO: rd_byte = r_period[7:0];
                            default:          rd_byte = {r_trig_seen, r_len_gate, 3'd0,
                                                         r_period[10:8]};
                        endcase
                    end else if (in_ram) begin
                        rd_byte = ram_rd.bus;
                    end
                end
                wsc_pkg::REQ_WRITE: begin
                    if (in_reg) begin
                        case (r_addr[3:0])
                            wsc_pkg::REG_DAC: n_dac_on = r_data[7];
                            wsc_pkg::REG_LEN: begin
                                n_len_reload = r_data;
                                n_len_count  = wsc_pkg::LENGTH_FULL - {1'b0, r_data};
                            end
                            wsc_pkg::REG_VOL: n_vol = r_data[6:5];
                            wsc_pkg::REG_PLO: n_period = {r_period[10:8], r_data};
                            default: begin
                                n_period    = trig_period;
                                n_len_gate  = r_data[6];
                                n_trig_seen = r_data[7];
                                if (r_data[7]) begin
                                    // trigger
                                    n_chan_on = 1'b1;
                                    if (r_len_count == 9'd0) begin
                                        n_len_count = wsc_pkg::LENGTH_FULL;
                                    end
                                    n_timer = wsc_pkg::reload_value(trig_period);
                                    n_pos   = 5'd0;
                                end
                            end
                        endcase
                    end
                end
                wsc_pkg::REQ_FREQ: begin
                    if (r_timer > 13'd1) begin
                        n_timer = r_timer - 13'd1;
                    end else begin
                        n_timer = wsc_pkg::reload_value(r_period);
                        n_pos   = pos_inc;
                        if (r_chan_on && r_dac_on) begin
                            n_level = wsc_pkg::vol_shift(nib, r_vol);
                        end else begin
                            n_level = 4'd0;
                        end
                    end
                end
                default: begin
                    if ((r_len_count != 9'd0) && r_len_gate) begin
                        n_len_count = r_len_count - 9'd1;
                        if (r_len_count == 9'd1) begin
                            n_chan_on = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    // ---------------- wave RAM ----------------
    // Reads for an item are issued as it enters the input register, addressed
    // from the state after this edge; the RAM forwards a same-edge write.
    assign n_pos_inc = n_pos + 5'd1;

    always_comb begin
        ram_ctl.we        = consume && (r_req == wsc_pkg::REQ_WRITE) && in_ram;
        ram_ctl.waddr     = r_addr[wsc_pkg::RAM_AW-1:0];
        ram_ctl.wdata     = r_data;
        ram_ctl.re        = in_acc;
        ram_ctl.raddr_bus = i_bus_address[wsc_pkg::RAM_AW-1:0];
        ram_ctl.raddr_smp = n_pos_inc[4:1];
    end

    wsc_wave_ram u_wave_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ram_ctl),
        .o_rd    (ram_rd)
    );

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_dac_on     <= 1'b0;
            r_len_reload <= 8'd0;
            r_len_count  <= 9'd0;
            r_vol        <= 2'd0;
            r_period     <= 11'd0;
            r_len_gate   <= 1'b0;
            r_trig_seen  <= 1'b0;
            r_chan_on    <= 1'b0;
            r_timer      <= 13'd0;
            r_pos        <= 5'd0;
            r_level      <= 4'd0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_dac_on     <= n_dac_on;
            r_len_reload <= n_len_reload;
            r_len_count  <= n_len_count;
            r_vol        <= n_vol;
            r_period     <= n_period;
            r_len_gate   <= n_len_gate;
            r_trig_seen  <= n_trig_seen;
            r_chan_on    <= n_chan_on;
            r_timer      <= n_timer;
            r_pos        <= n_pos;
            r_level      <= n_level;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= i_req_type;
            r_addr <= i_bus_address;
            r_data <= i_write_data;
        end
        if (consume) begin
            r_out_rd    <= rd_byte;
            r_out_level <= n_level;
            r_out_run   <= (n_len_count != 9'd0);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_out_rd;
    assign o_output_level   = r_out_level;
    assign o_length_running = r_out_run;

    // ---------------- assertions ----------------
    `ASSERT_IMPL(a_len_zero_off, r_len_count == 9'd0, !r_chan_on, "channel on with length zero")
    `ASSERT_IMPL(a_timer_range, 1'b1, r_timer <= 13'd4096, "period timer out of range")
    `ASSERT_NEXT(a_consume_out, consume, r_out_valid, "executed item left no result")
    `ASSERT_IMPL(a_stall_full, o_in_stall, r_in_valid && r_out_valid, "stall with free register")

endmodule

`default_nettype wire

### sv/wsc_wave_ram.sv
// ----------------------------------------------------------------------------
// wsc_wave_ram
// 16x8 wave RAM, one write port, two registered read ports with
// same-cycle write forwarding. Entries read as zero until first written.
// ----------------------------------------------------------------------------
`default_nettype none

module wsc_wave_ram (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wsc_pkg::t_ram_ctl i_ctl,
    output wsc_pkg::t_ram_rd       o_rd
);

    logic [7:0]                   r_mem [wsc_pkg::RAM_DEPTH];
    logic [wsc_pkg::RAM_DEPTH-1:0] r_vld;
    logic [7:0]                   r_rd_bus;
    logic [7:0]                   r_rd_smp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.we) begin
            r_vld[i_ctl.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        if (i_ctl.re) begin
            if (i_ctl.we && (i_ctl.waddr == i_ctl.raddr_bus)) begin
                r_rd_bus <= i_ctl.wdata;
            end else if (r_vld[i_ctl.raddr_bus]) begin
                r_rd_bus <= r_mem[i_ctl.raddr_bus];
            end else begin
                r_rd_bus <= 8'd0;
            end
            if (i_ctl.we && (i_ctl.waddr == i_ctl.raddr_smp)) begin
                r_rd_smp <= i_ctl.wdata;
            end else if (r_vld[i_ctl.raddr_smp]) begin
                r_rd_smp <= r_mem[i_ctl.raddr_smp];
            end else begin
                r_rd_smp <= 8'd0;
            end
        end
    end

    assign o_rd.bus = r_rd_bus;
    assign o_rd.smp = r_rd_smp;

endmodule

`default_nettype wire
